// File: rtl/mcwg_pkg.sv
// Shared constants and types of the Markov candidate word generator.
package mcwg_pkg;

    // Sizes of the chain tables and the odometer
    localparam int MAX_LEN     = 16;
    localparam int MAX_CHARSET = 64;
    localparam int ROWS        = 64;
    localparam int NUM_DIGITS  = MAX_LEN - 1;

    // Field widths
    localparam int CHAR_W  = 6;
    localparam int POS_W   = 4;
    localparam int LEN_W   = 5;
    localparam int RADIX_W = 7;
    localparam int BYTE_W  = 8;
    localparam int MODE_W  = 2;
    localparam int TBL_AW  = POS_W + 2 * CHAR_W;
    localparam int TBL_DEPTH = MAX_LEN * ROWS * ROWS;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHARSET_SIZE = 1'd1;

    // Reset values of the registers
    localparam logic [LEN_W-1:0]   WORD_LENGTH_RST  = 5'd1;
    localparam logic [RADIX_W-1:0] CHARSET_SIZE_RST = 7'd26;

    // Input item opcodes
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_RANK = 2'd0,
        MODE_LOAD_MAP  = 2'd1,
        MODE_START     = 2'd2,
        MODE_NEXT      = 2'd3
    } mode_t;

endpackage

// File: rtl/mcwg_in_if.sv
// Input channel: valid/ready handshake with one request payload.
interface mcwg_in_if;
    import mcwg_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [POS_W-1:0]  position;
    logic [CHAR_W-1:0] prev_index;
    logic [CHAR_W-1:0] rank;
    logic [BYTE_W-1:0] entry_value;
    logic [CHAR_W-1:0] first_rank;

    modport source (
        output valid, mode, position, prev_index, rank, entry_value, first_rank,
        input  ready
    );
    modport sink (
        input  valid, mode, position, prev_index, rank, entry_value, first_rank,
        output ready
    );
endinterface

// File: rtl/mcwg_out_if.sv
// Output channel: valid/ready handshake carrying one character result.
interface mcwg_out_if;
    import mcwg_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] char_byte;
    logic              last_char;
    logic              wrapped;
    logic              empty_res;

    modport source (
        output valid, char_byte, last_char, wrapped, empty_res,
        input  ready
    );
    modport sink (
        input  valid, char_byte, last_char, wrapped, empty_res,
        output ready
    );
endinterface

// File: rtl/mcwg_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mcwg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// File: rtl/markov_candidate_word_generator_unit.sv
// Markov candidate word generator: tables, word sequencer and suffix odometer.
// Load and start transactions are taken in the idle state; input is ready only
// there. A next transaction reads the rank table, then the char map, for each
// character and emits it once the output is free; unless the word wrapped, the
// odometer then steps one digit per cycle. An exhausted pair gives an empty result.
// Reset clears control state and loads the configuration reset values; the
// pair starts exhausted and both tables are undefined until loaded.
module markov_candidate_word_generator_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [mcwg_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mcwg_pkg::CFG_DATA_W-1:0]   cfg_data,
    mcwg_in_if.sink                           in_ch,
    mcwg_out_if.source                        out_ch
);
    import mcwg_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAP,
        ST_EMIT,
        ST_EMPTY,
        ST_ADV
    } state_t;

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   word_length_reg;
    logic [RADIX_W-1:0] charset_size_reg;
    logic [CHAR_W-1:0]  start_rank_reg, start_rank_next;
    logic               exhausted_reg, exhausted_next;
    logic [CHAR_W-1:0]  digits_reg [NUM_DIGITS];
    logic [CHAR_W-1:0]  digits_next [NUM_DIGITS];
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [POS_W-1:0]   dig_reg, dig_next;
    logic [CHAR_W-1:0]  idx_reg, idx_next;
    logic               all_full_reg, all_full_next;

    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic               out_wrap_reg, out_wrap_next;
    logic               out_empty_reg, out_empty_next;

    logic               tbl_we, tbl_re;
    logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
    logic [CHAR_W-1:0]  tbl_rdata;
    logic               map_we, map_re;
    logic [CHAR_W-1:0]  map_raddr;
    logic [BYTE_W-1:0]  map_rdata;

    logic               in_acc;
    logic               out_free;
    logic [LEN_W-1:0]   eff_len;
    logic [POS_W-1:0]   last_pos;
    logic [RADIX_W-1:0] eff_radix;
    logic [CHAR_W-1:0]  cur_digit;
    logic [CHAR_W-1:0]  adv_digit;

    // A digit at or above radix-1 cannot step without a carry
    function automatic logic digit_full(input logic [CHAR_W-1:0] d,
                                        input logic [RADIX_W-1:0] radix);
        logic [RADIX_W-1:0] inc;
        inc = {1'b0, d} + RADIX_W'(1);
        return inc >= radix;
    endfunction

    // Rank table and char map
    mcwg_ram #(.WIDTH(CHAR_W), .DEPTH(TBL_DEPTH)) u_rank_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (in_ch.entry_value[CHAR_W-1:0]),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    mcwg_ram #(.WIDTH(BYTE_W), .DEPTH(ROWS)) u_char_map (
        .clk   (clk),
        .we    (map_we),
        .waddr (in_ch.rank),
        .wdata (in_ch.entry_value),
        .re    (map_re),
        .raddr (map_raddr),
        .rdata (map_rdata)
    );

    assign tbl_waddr = {in_ch.position, in_ch.prev_index, in_ch.rank};

    // Handshakes
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_acc      = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.char_byte = out_byte_reg;
    assign out_ch.last_char = out_last_reg;
    assign out_ch.wrapped   = out_wrap_reg;
    assign out_ch.empty_res = out_empty_reg;

    // Clamped register values
    always_comb
    begin
        if (word_length_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (word_length_reg > LEN_W'(MAX_LEN))
        begin
            eff_len = LEN_W'(MAX_LEN);
        end
        else
        begin
            eff_len = word_length_reg;
        end
        if (charset_size_reg == '0)
        begin
            eff_radix = RADIX_W'(1);
        end
        else if (charset_size_reg > RADIX_W'(MAX_CHARSET))
        begin
            eff_radix = RADIX_W'(MAX_CHARSET);
        end
        else
        begin
            eff_radix = charset_size_reg;
        end
    end

    assign last_pos  = POS_W'(eff_len - LEN_W'(1));
    assign cur_digit = digits_reg[pos_reg];
    assign adv_digit = digits_reg[dig_reg];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_length_reg  <= WORD_LENGTH_RST;
            charset_size_reg <= CHARSET_SIZE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WORD_LENGTH:  word_length_reg  <= cfg_data[LEN_W-1:0];
                CFG_CHARSET_SIZE: charset_size_reg <= cfg_data[RADIX_W-1:0];
                default:          ;
            endcase
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        start_rank_next = start_rank_reg;
        exhausted_next  = exhausted_reg;
        digits_next     = digits_reg;
        pos_next        = pos_reg;
        dig_next        = dig_reg;
        idx_next        = idx_reg;
        all_full_next   = all_full_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;
        out_wrap_next   = out_wrap_reg;
        out_empty_next  = out_empty_reg;
        tbl_we          = 1'b0;
        tbl_re          = 1'b0;
        tbl_raddr       = '0;
        map_we          = 1'b0;
        map_re          = 1'b0;
        map_raddr       = tbl_rdata;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (mode_t'(in_ch.mode))
                        MODE_LOAD_RANK: tbl_we = 1'b1;
                        MODE_LOAD_MAP:  map_we = 1'b1;
                        MODE_START:
                        begin
                            start_rank_next = in_ch.first_rank;
                            exhausted_next  = 1'b0;
                            for (int i = 0; i < NUM_DIGITS; i++)
                            begin
                                digits_next[i] = '0;
                            end
                        end
                        MODE_NEXT:
                        begin
                            if (exhausted_reg)
                            begin
                                state_next = ST_EMPTY;
                            end
                            else
                            begin
                                // First character: position 0, row 0
                                tbl_re        = 1'b1;
                                tbl_raddr     = {POS_W'(0), CHAR_W'(0), start_rank_reg};
                                pos_next      = '0;
                                all_full_next = 1'b1;
                                state_next    = ST_MAP;
                            end
                        end
                    endcase
                end
            end

            ST_MAP:
            begin
                map_re     = 1'b1;
                idx_next   = tbl_rdata;
                state_next = ST_EMIT;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = map_rdata;
                    out_empty_next = 1'b0;
                    if (pos_reg == last_pos)
                    begin
                        out_last_next  = 1'b1;
                        out_wrap_next  = all_full_reg;
                        exhausted_next = all_full_reg;
                        // On a wrap the pair is dead; a start clears the digits
                        if (all_full_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            dig_next   = last_pos - POS_W'(1);
                            state_next = ST_ADV;
                        end
                    end
                    else
                    begin
                        out_last_next = 1'b0;
                        out_wrap_next = 1'b0;
                        // Next character chained through this one's index
                        tbl_re        = 1'b1;
                        tbl_raddr     = {pos_reg + POS_W'(1), idx_reg, cur_digit};
                        all_full_next = all_full_reg && digit_full(cur_digit, eff_radix);
                        pos_next      = pos_reg + POS_W'(1);
                        state_next    = ST_MAP;
                    end
                end
            end

            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = '0;
                    out_last_next  = 1'b1;
                    out_wrap_next  = 1'b0;
                    out_empty_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_ADV:
            begin
                // One odometer digit per cycle, least significant first
                if (!digit_full(adv_digit, eff_radix))
                begin
                    digits_next[dig_reg] = adv_digit + CHAR_W'(1);
                    state_next           = ST_IDLE;
                end
                else
                begin
                    digits_next[dig_reg] = '0;
                    if (dig_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        dig_next = dig_reg - POS_W'(1);
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            start_rank_reg <= '0;
            exhausted_reg  <= 1'b1;
            for (int i = 0; i < NUM_DIGITS; i++)
            begin
                digits_reg[i] <= '0;
            end
            pos_reg        <= '0;
            dig_reg        <= '0;
            all_full_reg   <= 1'b1;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            start_rank_reg <= start_rank_next;
            exhausted_reg  <= exhausted_next;
            digits_reg     <= digits_next;
            pos_reg        <= pos_next;
            dig_reg        <= dig_next;
            all_full_reg   <= all_full_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
        out_wrap_reg  <= out_wrap_next;
        out_empty_reg <= out_empty_next;
    end
endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking randomized testbench for the Markov candidate word generator.
module tb_top;
    import mcwg_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_WORDS  = 20;

    // One request on the input channel
    typedef struct {
        mode_t             mode;
        logic [POS_W-1:0]  position;
        logic [CHAR_W-1:0] prev_index;
        logic [CHAR_W-1:0] rank;
        logic [BYTE_W-1:0] entry_value;
        logic [CHAR_W-1:0] first_rank;
    } gen_req_t;

    // One character on the output channel
    typedef struct {
        logic [BYTE_W-1:0] char_byte;
        logic              last_char;
        logic              wrapped;
        logic              empty_res;
    } word_char_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    mcwg_in_if  in_ch ();
    mcwg_out_if out_ch ();

    markov_candidate_word_generator_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow copy of the chain tables; *_known marks entries already loaded
    logic [CHAR_W-1:0]  chain_rank [TBL_DEPTH];
    bit                 chain_known [TBL_DEPTH];
    logic [BYTE_W-1:0]  byte_map [ROWS];
    bit                 byte_known [ROWS];
    logic [CHAR_W-1:0]  odo_digit [NUM_DIGITS];
    logic [CHAR_W-1:0]  pair_first_rank;
    bit                 pair_done;
    logic [LEN_W-1:0]   word_len_reg;
    logic [RADIX_W-1:0] radix_reg;

    word_char_t expected_chars [$];
    int         err_cnt;
    int         word_reqs;
    bit         tx_idle_on;
    bit         rx_idle_on;
    logic       rx_hold;

    always #1 clk = ~clk;

    // Clamped register values
    function automatic int unsigned word_len_eff();
        int unsigned l;
        l = word_len_reg;
        if (l < 1)
            l = 1;
        if (l > MAX_LEN)
            l = MAX_LEN;
        return l;
    endfunction

    function automatic int unsigned radix_eff();
        int unsigned r;
        r = radix_reg;
        if (r < 1)
            r = 1;
        if (r > MAX_CHARSET)
            r = MAX_CHARSET;
        if (r > ROWS)
            r = ROWS;
        return r;
    endfunction

    function automatic logic [TBL_AW-1:0] chain_addr(input logic [POS_W-1:0] pos,
                                                     input logic [CHAR_W-1:0] prev,
                                                     input logic [CHAR_W-1:0] digit);
        return {pos, prev, digit};
    endfunction

    // Update the shadow state for one accepted request and queue its characters
    function automatic void predict_item(input gen_req_t r);
        word_char_t        c;
        logic [CHAR_W-1:0] idx;
        logic [BYTE_W-1:0] chars [MAX_LEN];
        logic [TBL_AW-1:0] a;
        int unsigned       len;
        int unsigned       k;
        bit                wrap;
        case (r.mode)
            MODE_LOAD_RANK:
            begin
                a = chain_addr(r.position, r.prev_index, r.rank);
                chain_rank[a]  = r.entry_value[CHAR_W-1:0];
                chain_known[a] = 1'b1;
            end
            MODE_LOAD_MAP:
            begin
                byte_map[r.rank]   = r.entry_value;
                byte_known[r.rank] = 1'b1;
            end
            MODE_START:
            begin
                pair_first_rank = r.first_rank;
                for (k = 0; k < NUM_DIGITS; k++)
                    odo_digit[k] = '0;
                pair_done = 1'b0;
            end
            default:
            begin
                if (pair_done)
                begin
                    // next on an exhausted pair: single empty marker
                    c.char_byte = '0;
                    c.last_char = 1'b1;
                    c.wrapped   = 1'b0;
                    c.empty_res = 1'b1;
                    expected_chars.push_back(c);
                end
                else
                begin
                    len = word_len_eff();
                    idx = chain_rank[chain_addr('0, '0, pair_first_rank)];
                    chars[0] = byte_map[idx];
                    for (k = 1; k < len; k++)
                    begin
                        idx = chain_rank[chain_addr(POS_W'(k), idx, odo_digit[k-1])];
                        chars[k] = byte_map[idx];
                    end
                    // odometer step, last digit in use is least significant;
                    // a digit at or above radix-1 is cleared and carries
                    wrap = 1'b1;
                    for (k = len - 1; k > 0 && wrap; k--)
                    begin
                        if (int'(odo_digit[k-1]) + 1 < radix_eff())
                        begin
                            odo_digit[k-1] = odo_digit[k-1] + 1'b1;
                            wrap = 1'b0;
                        end
                        else
                            odo_digit[k-1] = '0;
                    end
                    if (wrap)
                        pair_done = 1'b1;
                    for (k = 0; k < len; k++)
                    begin
                        c.char_byte = chars[k];
                        c.last_char = (k == len - 1);
                        c.wrapped   = (k == len - 1) && wrap;
                        c.empty_res = 1'b0;
                        expected_chars.push_back(c);
                    end
                end
            end
        endcase
    endfunction

    // Request of the given kind with every field random
    function automatic gen_req_t noise_req(input mode_t m);
        gen_req_t r;
        r.mode        = m;
        r.position    = POS_W'($urandom);
        r.prev_index  = CHAR_W'($urandom);
        r.rank        = CHAR_W'($urandom);
        r.entry_value = BYTE_W'($urandom);
        r.first_rank  = CHAR_W'($urandom);
        return r;
    endfunction

    // Offer one request and hold it until the block takes it
    task automatic send_item(input gen_req_t r);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.mode        <= r.mode;
        in_ch.position    <= r.position;
        in_ch.prev_index  <= r.prev_index;
        in_ch.rank        <= r.rank;
        in_ch.entry_value <= r.entry_value;
        in_ch.first_rank  <= r.first_rank;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        predict_item(r);
        if (r.mode == MODE_START || r.mode == MODE_NEXT)
            word_reqs++;
    endtask

    // Load every table entry that the coming word will read and is still unset
    task automatic fill_chain_path();
        gen_req_t          r;
        logic [TBL_AW-1:0] a;
        logic [CHAR_W-1:0] idx;
        int unsigned       k;
        idx = '0;
        if (!pair_done)
        begin
            for (k = 0; k < word_len_eff(); k++)
            begin
                if (k == 0)
                    a = chain_addr('0, '0, pair_first_rank);
                else
                    a = chain_addr(POS_W'(k), idx, odo_digit[k-1]);
                if (!chain_known[a])
                begin
                    r = noise_req(MODE_LOAD_RANK);
                    {r.position, r.prev_index, r.rank} = a;
                    send_item(r);
                end
                idx = chain_rank[a];
                if (!byte_known[idx])
                begin
                    r = noise_req(MODE_LOAD_MAP);
                    r.rank = idx;
                    send_item(r);
                end
            end
        end
    endtask

    task automatic next_word();
        fill_chain_path();
        send_item(noise_req(MODE_NEXT));
    endtask

    task automatic start_pair(input logic [CHAR_W-1:0] first);
        gen_req_t r;
        r = noise_req(MODE_START);
        r.first_rank = first;
        send_item(r);
    endtask

    // Stop offering and wait until the block has gone quiet
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Both registers, written back to back once the block is idle
    task automatic set_config(input logic [LEN_W-1:0] len, input logic [RADIX_W-1:0] radix);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WORD_LENGTH;
        cfg_data  <= CFG_DATA_W'(len);
        @(posedge clk);
        word_len_reg = len;
        cfg_index <= CFG_CHARSET_SIZE;
        cfg_data  <= CFG_DATA_W'(radix);
        @(posedge clk);
        radix_reg = radix;
        cfg_we <= 1'b0;
    endtask

    // Compare one accepted character with the oldest expectation
    task automatic check_result();
        word_char_t e;
        if (expected_chars.size() == 0)
        begin
            $error("result with nothing expected: char_byte %0h", out_ch.char_byte);
            err_cnt++;
        end
        else
        begin
            e = expected_chars.pop_front();
            if (out_ch.char_byte !== e.char_byte)
            begin
                $error("char_byte: expected %0h, got %0h", e.char_byte, out_ch.char_byte);
                err_cnt++;
            end
            if (out_ch.last_char !== e.last_char)
            begin
                $error("last_char: expected %0b, got %0b", e.last_char, out_ch.last_char);
                err_cnt++;
            end
            if (out_ch.wrapped !== e.wrapped)
            begin
                $error("wrapped: expected %0b, got %0b", e.wrapped, out_ch.wrapped);
                err_cnt++;
            end
            if (out_ch.empty_res !== e.empty_res)
            begin
                $error("empty_res: expected %0b, got %0b", e.empty_res, out_ch.empty_res);
                err_cnt++;
            end
        end
    endtask

    // Receiver: checks each transaction, then draws its own ready gap
    initial
    begin : result_sink
        int gap;
        gap = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (out_ch.valid && out_ch.ready)
                begin
                    check_result();
                    gap = rx_idle_on ? $urandom_range(0, 8) : 0;
                end
                else if (gap > 0)
                    gap--;
                out_ch.ready <= !rx_hold && gap == 0;
            end
        end
    end

    // Watchdog on cycles with no transaction on either channel
    initial
    begin : stall_watch
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $error("no transaction for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Pair starts exhausted; default length one gives a single wrapped byte
    task automatic test_reset_and_length_one();
        next_word();
        start_pair(CHAR_W'($urandom));
        next_word();
        next_word();
    endtask

    // Widest settings and all-ones / all-zeros field values
    task automatic test_field_extremes();
        gen_req_t r;
        set_config(5'd31, 7'd127);
        r = noise_req(MODE_LOAD_RANK);
        r.position    = '0;
        r.prev_index  = '0;
        r.rank        = '1;
        r.entry_value = '1;
        send_item(r);
        r = noise_req(MODE_LOAD_MAP);
        r.rank        = '1;
        r.entry_value = '1;
        send_item(r);
        r = noise_req(MODE_LOAD_MAP);
        r.rank        = '0;
        r.entry_value = '0;
        send_item(r);
        r = noise_req(MODE_LOAD_RANK);
        r.position    = '1;
        r.prev_index  = '1;
        r.rank        = '1;
        r.entry_value = '0;
        send_item(r);
        start_pair('1);
        next_word();
        next_word();
        // zero registers clamp to length one, radix one
        set_config(5'd0, 7'd0);
        start_pair('0);
        next_word();
        next_word();
    endtask

    // Radix one: the first word of a pair wraps
    task automatic test_radix_one();
        set_config(5'd3, 7'd1);
        start_pair(CHAR_W'($urandom));
        next_word();
        next_word();
    endtask

    // Shrink the radix under digits that are already larger than it
    task automatic test_digit_over_radix();
        int n;
        set_config(5'd3, 7'd4);
        start_pair(CHAR_W'($urandom));
        repeat (7) next_word();
        set_config(5'd3, 7'd3);
        n = 0;
        while (!pair_done && n < 20)
        begin
            next_word();
            n++;
        end
        next_word();
    endtask

    // Random phases: settings, a pair, then a run of words with some noise
    task automatic test_random_pairs();
        int goal;
        int n;
        goal = word_reqs + RANDOM_WORDS;
        while (word_reqs < goal)
        begin
            if ($urandom_range(0, 5) == 0)
                set_config($urandom_range(0, 1) ? 5'd16 : 5'(31 - $urandom_range(0, 14)),
                           $urandom_range(0, 1) ? 7'd64 : 7'(127 - $urandom_range(0, 62)));
            else
                set_config(5'($urandom_range(1, 4)), 7'($urandom_range(1, 4)));
            tx_idle_on = $urandom_range(0, 1);
            rx_idle_on = $urandom_range(0, 1);
            if ($urandom_range(0, 4) != 0)
                start_pair(CHAR_W'($urandom));
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                case ($urandom_range(0, 9))
                    0:       send_item(noise_req(MODE_LOAD_RANK));
                    1:       send_item(noise_req(MODE_LOAD_MAP));
                    2:       start_pair(CHAR_W'($urandom));
                    default: next_word();
                endcase
            end
        end
    endtask

    // Receiver held off while words keep coming, so the input backs up
    task automatic test_long_stall();
        set_config(5'd8, 7'd8);
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        start_pair(CHAR_W'($urandom));
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            repeat (12) next_word();
        join
        drain();
    endtask

    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = CFG_WORD_LENGTH;
        cfg_data          = '0;
        in_ch.valid       = 1'b0;
        in_ch.mode        = MODE_LOAD_RANK;
        in_ch.position    = '0;
        in_ch.prev_index  = '0;
        in_ch.rank        = '0;
        in_ch.entry_value = '0;
        in_ch.first_rank  = '0;
        rx_hold           = 1'b0;
        tx_idle_on        = 1'b0;
        rx_idle_on        = 1'b0;
        err_cnt           = 0;
        word_reqs         = 0;
        // shadow state after reset
        for (int k = 0; k < NUM_DIGITS; k++)
            odo_digit[k] = '0;
        pair_first_rank = '0;
        pair_done       = 1'b1;
        word_len_reg    = WORD_LENGTH_RST;
        radix_reg       = CHARSET_SIZE_RST;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_and_length_one();
        test_field_extremes();
        test_radix_one();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        test_digit_over_radix();
        test_random_pairs();
        test_long_stall();
        drain();

        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
